@@ rtl/kpi_pkg.sv @@
// Shared types, sizes and codes for the keyframe path interpolator.
// Used by every module under rtl; depends on nothing.
package kpi_pkg;

  localparam int MAX_SEGMENTS = 16;

  localparam int COORD_W  = 12;
  localparam int DUR_W    = 16;
  localparam int QTIME_W  = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  localparam int SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int COUNT_W   = $clog2(MAX_SEGMENTS + 1);
  // Sum of all segment durations never exceeds MAX_SEGMENTS * 65535.
  localparam int TOTAL_W   = $clog2(MAX_SEGMENTS * 65535 + 1);
  // |end - start| * time within a segment.
  localparam int PROD_W    = COORD_W + DUR_W;
  localparam int DIVD_W    = QTIME_W;
  localparam int DCNT_W    = $clog2(DIVD_W);

  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DUR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [DUR_W-1:0]   duration;
    logic [QTIME_W-1:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [DUR_W-1:0]   dur;
  } seg_t;

  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  dividend;
    logic [TOTAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIVD_W-1:0]  quotient;
    logic [TOTAL_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_GO,
    S_MOD_WAIT,
    S_WALK,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

endpackage

@@ rtl/kpi_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on kpi_pkg for widths and the request/response structs.
module kpi_divider (
  input  logic               clk,
  input  logic               rst,
  input  kpi_pkg::div_req_t  req,
  output kpi_pkg::div_rsp_t  rsp
);
  import kpi_pkg::*;

  logic               running;
  logic               done;
  logic [DCNT_W-1:0]  cnt;
  logic [DIVD_W-1:0]  quo;
  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] divisor;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;

  assign trial = {rem, quo[DIVD_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
      end else if (running) begin
        // Subtract when the shifted remainder covers the divisor.
        if (!diff[TOTAL_W]) begin
          rem <= diff[TOTAL_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[TOTAL_W-1:0];
          quo <= {quo[DIVD_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ rtl/kpi_seg_table.sv @@
// Segment table: one write port, one registered read port.
// Depends on kpi_pkg for the segment record and index width.
module kpi_seg_table (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [kpi_pkg::SEG_IDX_W-1:0] wr_addr,
  input  kpi_pkg::seg_t                 wr_data,
  input  logic                          rd_en,
  input  logic [kpi_pkg::SEG_IDX_W-1:0] rd_addr,
  output kpi_pkg::seg_t                 rd_data
);
  import kpi_pkg::*;

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/keyframe_path_interpolator.sv @@
// Keyframe path interpolator: looping path of straight segments, queried by time.
// Clear, append, ignored and empty-path query transfers strobe a result in the next cycle.
// A query holds busy through the modulo, the walk to its segment, and a multiply and
// a divide per axis; the done strobe comes in the cycle in which busy drops.
// The modulo and both divisions share the 32-step restoring divider; the receiver cannot stall.
// Synchronous active-high reset empties the path; table contents stay undefined until appended.
module keyframe_path_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  kpi_pkg::in_item_t  cmd,
  output logic               done,
  output kpi_pkg::out_item_t result
);
  import kpi_pkg::*;

  state_t state, state_next;

  // Path bookkeeping.
  logic [COUNT_W-1:0]   seg_count;
  logic [TOTAL_W-1:0]   total;

  // Query working registers.
  logic [QTIME_W-1:0]   qtime;
  logic [TOTAL_W-1:0]   t_rem;
  logic [SEG_IDX_W-1:0] idx;
  seg_t                 seg;
  logic                 axis;      // 0 while working on x, 1 on y
  logic [PROD_W-1:0]    prod;
  logic                 neg;
  logic [COORD_W-1:0]   x_res;

  // Shared units.
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic                 wr_en;
  seg_t                 wr_data;
  logic                 rd_en;
  logic [SEG_IDX_W-1:0] rd_addr;
  seg_t                 rd_data;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 advance;
  logic [COORD_W-1:0]   base;
  logic [COORD_W-1:0]   target;
  logic [COORD_W:0]     delta;
  logic [COORD_W:0]     delta_neg;
  logic [COORD_W-1:0]   mag;
  logic [COORD_W-1:0]   quot;
  logic [COORD_W-1:0]   coord;

  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign full    = (seg_count >= COUNT_W'(MAX_SEGMENTS));
  assign empty   = (seg_count == '0) || (total == '0);
  // Step past the segment while the remaining time strictly exceeds its duration.
  assign advance = (t_rem > TOTAL_W'(rd_data.dur));

  // Signed span of the active axis, split into magnitude and sign for the divider.
  assign base      = axis ? seg.sy : seg.sx;
  assign target    = axis ? seg.ey : seg.ex;
  assign delta     = {1'b0, target} - {1'b0, base};
  assign delta_neg = -delta;
  assign mag       = delta[COORD_W] ? delta_neg[COORD_W-1:0] : delta[COORD_W-1:0];
  // Quotient magnitude never exceeds the span, so the low bits carry it all.
  assign quot      = div_rsp.quotient[COORD_W-1:0];
  assign coord     = neg ? (base - quot) : (base + quot);

  assign wr_data.sx  = cmd.start_x;
  assign wr_data.sy  = cmd.start_y;
  assign wr_data.ex  = cmd.end_x;
  assign wr_data.ey  = cmd.end_y;
  assign wr_data.dur = cmd.duration;

  kpi_seg_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (seg_count[SEG_IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kpi_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_next       = state;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = idx;
    div_req.start    = 1'b0;
    div_req.dividend = qtime;
    div_req.divisor  = total;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.func == FN_APPEND) begin
            wr_en = !full && (cmd.duration != '0);
          end else if (cmd.func == FN_QUERY && !empty) begin
            state_next = S_MOD_GO;
          end
        end
      end
      S_MOD_GO: begin
        div_req.start = 1'b1;
        state_next    = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        if (div_rsp.done) begin
          // Fetch the first segment while the remainder lands.
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (advance) begin
          rd_en   = 1'b1;
          rd_addr = idx + 1'b1;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(prod);
        div_req.divisor  = TOTAL_W'(seg.dur);
        state_next       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = axis ? S_IDLE : S_MUL;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      seg_count <= '0;
      total     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            result.pos_x  <= '0;
            result.pos_y  <= '0;
            result.status <= ST_OK;
            case (cmd.func)
              FN_CLEAR: begin
                seg_count <= '0;
                total     <= '0;
                done      <= 1'b1;
              end
              FN_APPEND: begin
                if (full) begin
                  result.status <= ST_FULL;
                end else if (cmd.duration == '0) begin
                  result.status <= ST_ZERO_DUR;
                end else begin
                  seg_count <= seg_count + 1'b1;
                  total     <= total + TOTAL_W'(cmd.duration);
                end
                done <= 1'b1;
              end
              FN_QUERY: begin
                if (empty) begin
                  result.status <= ST_EMPTY;
                  done          <= 1'b1;
                end else begin
                  qtime <= cmd.query_time;
                end
              end
              default: begin
                // Unused selector: no state change, plain ok result.
                done <= 1'b1;
              end
            endcase
          end
        end
        S_MOD_WAIT: begin
          if (div_rsp.done) begin
            t_rem <= div_rsp.remainder;
            idx   <= '0;
          end
        end
        S_WALK: begin
          if (advance) begin
            t_rem <= t_rem - TOTAL_W'(rd_data.dur);
            idx   <= idx + 1'b1;
          end else begin
            seg  <= rd_data;
            axis <= 1'b0;
          end
        end
        S_MUL: begin
          // Remaining time is within this segment, so it fits a duration.
          prod <= PROD_W'(mag) * PROD_W'(t_rem[DUR_W-1:0]);
          neg  <= delta[COORD_W];
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (!axis) begin
              x_res <= coord;
              axis  <= 1'b1;
            end else begin
              result.pos_x  <= x_res;
              result.pos_y  <= coord;
              result.status <= ST_OK;
              done          <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
